// ===== design/dart_pkg.sv =====
// Shared types and constants for the divider and reload timer.
package dart_pkg;

    // Item kinds
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    // Register map
    localparam logic [15:0] ADDR_DIV = 16'hFF04;
    localparam logic [15:0] ADDR_CNT = 16'hFF05;
    localparam logic [15:0] ADDR_MOD = 16'hFF06;
    localparam logic [15:0] ADDR_CTL = 16'hFF07;

    // Control register fields
    localparam int          CTL_EN_BIT   = 2;
    localparam logic [7:0]  CTL_RD_FILL  = 8'hF8;
    localparam logic [7:0]  UNMAPPED_RD  = 8'hFF;
    localparam logic [7:0]  CNT_MAX      = 8'hFF;

    // Clock select codes (control bits 1:0)
    localparam logic [1:0] SEL_1024 = 2'd0;
    localparam logic [1:0] SEL_16   = 2'd1;
    localparam logic [1:0] SEL_64   = 2'd2;
    localparam logic [1:0] SEL_256  = 2'd3;

    localparam int ACC_W = 11;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOP = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    typedef struct packed {
        logic accept;    // latch a new transaction
        logic step;      // one counter step
        logic load_out;  // move result into output register
    } cmd_t;

    typedef struct packed {
        logic step_pending;  // timer enabled and accumulator holds a full period
    } status_t;

    function automatic logic [ACC_W-1:0] period_of(input logic [1:0] sel);
        logic [ACC_W-1:0] per;
        case (sel)
            SEL_16:   per = 11'd16;
            SEL_64:   per = 11'd64;
            SEL_256:  per = 11'd256;
            SEL_1024: per = 11'd1024;
            default:  per = 11'd1024;
        endcase
        return per;
    endfunction

endpackage

// ===== design/divider_and_reload_timer.sv =====
// Top level of the divider and reload timer peripheral.
// Register-mapped timer at 0xFF04 (divider), 0xFF05 (counter), 0xFF06 (modulo)
// and 0xFF07 (control). Each input transaction is a tick, a register read or a
// register write, and returns exactly one output transaction. A read or write
// passes from acceptance to the result stage, which moves its result into the
// output register. A tick first runs the step loop, which makes one counter
// step for each full period pending, because the datapath advances the counter
// one period per cycle. A tick causes at most 79 steps, when a period of 16
// drains a nearly full accumulator. The next transaction is accepted in the
// cycle after a result moves into the output register, even if that result is
// not yet taken; the block stalls only when a new result is ready and the
// previous one still waits. There is no clearing pass after reset.
module divider_and_reload_timer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [15:0] address,
    input  logic [7:0]  write_value,
    input  logic [7:0]  cycles,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic        timer_irq
);

    dart_pkg::cmd_t    cmd;
    dart_pkg::status_t status;

    // sequencing: idle -> (step loop for ticks) -> result load
    dart_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // timer state, register access and output payload
    dart_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .action      (action),
        .address     (address),
        .write_value (write_value),
        .cycles      (cycles),
        .read_data   (read_data),
        .timer_irq   (timer_irq)
    );

endmodule

// ===== design/dart_ctrl.sv =====
// Controller state machine: sequences accept, counter steps and result load.
module dart_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            action,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  dart_pkg::status_t     status,
    output dart_pkg::cmd_t        cmd
);

    dart_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == dart_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.step     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            dart_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (action == dart_pkg::ACT_TICK) ? dart_pkg::S_LOOP
                                                                : dart_pkg::S_FIN;
                end
            end
            dart_pkg::S_LOOP:
            begin
                if (status.step_pending)
                    cmd.step = 1'b1;
                else
                    state_next = dart_pkg::S_FIN;
            end
            dart_pkg::S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = dart_pkg::S_IDLE;
                end
            end
            default: state_next = dart_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dart_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // loop exits to result stage once no full period remains
    a_loop_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dart_pkg::S_LOOP && !status.step_pending)
            |=> state_reg == dart_pkg::S_FIN)
        else $error("loop did not exit");

    // result never overwrites one still waiting
    a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

    // reads, writes and unknown actions skip the step loop
    a_no_loop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && action != dart_pkg::ACT_TICK)
            |=> state_reg == dart_pkg::S_FIN)
        else $error("non-tick entered loop");

endmodule

// ===== design/dart_dp.sv =====
// Datapath: timer registers, accumulators, register file access, output register.
module dart_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  dart_pkg::cmd_t     cmd,
    output dart_pkg::status_t  status,
    input  logic [1:0]         action,
    input  logic [15:0]        address,
    input  logic [7:0]         write_value,
    input  logic [7:0]         cycles,
    output logic [7:0]         read_data,
    output logic               timer_irq
);

    logic [7:0]                 div_byte_reg, cnt_byte_reg, mod_byte_reg;
    logic [2:0]                 ctl_reg;
    logic [7:0]                 div_acc_reg;
    logic [dart_pkg::ACC_W-1:0] cnt_acc_reg;
    logic [7:0]                 rd_reg;
    logic                       irq_reg;
    logic [7:0]                 read_data_reg;
    logic                       timer_irq_reg;

    logic [8:0]                 div_sum;
    logic [dart_pkg::ACC_W-1:0] period;
    logic [7:0]                 rd_mux;

    assign div_sum = {1'b0, div_acc_reg} + {1'b0, cycles};
    assign period  = dart_pkg::period_of(ctl_reg[1:0]);
    assign status.step_pending = ctl_reg[dart_pkg::CTL_EN_BIT] && (cnt_acc_reg >= period);

    always_comb
    begin
        case (address)
            dart_pkg::ADDR_DIV: rd_mux = div_byte_reg;
            dart_pkg::ADDR_CNT: rd_mux = cnt_byte_reg;
            dart_pkg::ADDR_MOD: rd_mux = mod_byte_reg;
            dart_pkg::ADDR_CTL: rd_mux = {5'b0, ctl_reg} | dart_pkg::CTL_RD_FILL;
            default:            rd_mux = dart_pkg::UNMAPPED_RD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_byte_reg <= '0;
            cnt_byte_reg <= '0;
            mod_byte_reg <= '0;
            ctl_reg      <= '0;
            div_acc_reg  <= '0;
            cnt_acc_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            case (action)
                dart_pkg::ACT_TICK:
                begin
                    div_acc_reg  <= div_sum[7:0];
                    div_byte_reg <= div_byte_reg + {7'b0, div_sum[8]};
                    if (ctl_reg[dart_pkg::CTL_EN_BIT])
                        cnt_acc_reg <= cnt_acc_reg + {3'b0, cycles};
                end
                dart_pkg::ACT_WRITE:
                begin
                    case (address)
                        dart_pkg::ADDR_DIV: div_byte_reg <= write_value;
                        dart_pkg::ADDR_CNT: cnt_byte_reg <= write_value;
                        dart_pkg::ADDR_MOD: mod_byte_reg <= write_value;
                        dart_pkg::ADDR_CTL: ctl_reg      <= write_value[2:0];
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        else if (cmd.step)
        begin
            cnt_acc_reg <= cnt_acc_reg - period;
            if (cnt_byte_reg == dart_pkg::CNT_MAX)
                cnt_byte_reg <= mod_byte_reg;
            else
                cnt_byte_reg <= cnt_byte_reg + 8'd1;
        end
    end

    // per-transaction result
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_reg  <= (action == dart_pkg::ACT_READ) ? rd_mux : 8'd0;
            irq_reg <= 1'b0;
        end
        else if (cmd.step && cnt_byte_reg == dart_pkg::CNT_MAX)
            irq_reg <= 1'b1;
        if (cmd.load_out)
        begin
            read_data_reg <= rd_reg;
            timer_irq_reg <= irq_reg;
        end
    end

    assign read_data = read_data_reg;
    assign timer_irq = timer_irq_reg;

    // a step is only commanded while a full period is pending
    a_step_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> status.step_pending)
        else $error("step without full period");

    // accumulator never exceeds the largest value a tick can build
    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_acc_reg <= 11'd1278)
        else $error("counter accumulator out of range");

endmodule
